FILE: rtl/rls_pkg.sv
// Package for the two-parameter RLS estimator: arithmetic helpers, register indexes and the
// command and status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
package rls_pkg;

  localparam int SigFrac = 16;
  localparam int CovFrac = 24;

  localparam logic [0:0] RegLambda    = 1'b0;
  localparam logic [0:0] RegThreshold = 1'b1;

  localparam logic [16:0] LambdaReset    = 17'd64880;
  localparam logic [30:0] ThresholdReset = 31'd655;

  // Operation codes for the shared multiply and divide units.
  typedef enum logic [3:0] {
    OpPe0a, OpPe0b, OpPe1a, OpPe1b, OpDen0, OpDen1, OpErr0, OpErr1,
    OpW0, OpW1, OpC0, OpC1, OpC2
  } mul_op_e;

  typedef enum logic [2:0] {
    DivG0, DivG1, DivP0, DivP1, DivP2
  } div_op_e;

  typedef struct packed {
    logic    load;      // capture inputs, decide excitation
    logic    mul_go;
    mul_op_e mul_op;
    logic    div_go;
    div_op_e div_op;
    logic    commit;    // write new weights
  } rls_cmd_t;

  typedef struct packed {
    logic excited;
    logic mul_done;
    logic div_done;
  } rls_stat_t;

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b,
                                           output logic clip);
    logic [64:0] s;
    begin
      s = {a[63], a} + {b[63], b};
      clip = s[64] != s[63];
      if (clip) sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      else sat_add64 = s[63:0];
    end
  endfunction

  function automatic logic [63:0] sat_sub64(input logic [63:0] a, input logic [63:0] b,
                                           output logic clip);
    logic [64:0] s;
    begin
      s = {a[63], a} - {b[63], b};
      clip = s[64] != s[63];
      if (clip) sat_sub64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      else sat_sub64 = s[63:0];
    end
  endfunction

  // Saturate a 64 bit value to a signed field of width w.
  function automatic logic [63:0] clamp64(input logic [63:0] x, input int w, output logic clip);
    logic signed [63:0] xs, top, bot;
    begin
      xs = signed'(x);
      clip = 1'b0;
      clamp64 = x;
      if (w < 64) begin
        top = signed'(64'hFFFF_FFFF_FFFF_FFFF >> (65 - w));
        bot = -top - 64'sd1;
        if (xs > top) begin
          clamp64 = top;
          clip = 1'b1;
        end else if (xs < bot) begin
          clamp64 = bot;
          clip = 1'b1;
        end
      end
    end
  endfunction

endpackage

FILE: rtl/rls_mul.sv
// Sequential signed multiplier with floor shift and 64 bit saturation.
// Uses 32x32 partial products, one per cycle. Depends on rls_pkg.
`timescale 1ns / 1ps
module rls_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  input  logic        frac24_i,
  output logic        done_o,
  output logic [63:0] res_o,
  output logic        clip_o
);
  import rls_pkg::*;

  logic [63:0]  ma_q, mb_q;
  logic         neg_q, f24_q;
  logic [127:0] acc_q;
  logic [2:0]   step_q;
  logic         busy_q;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [127:0] biased, shifted;

  always_comb begin
    pa = step_q[1] ? ma_q[63:32] : ma_q[31:0];
    pb = step_q[0] ? mb_q[63:32] : mb_q[31:0];
    pp = 64'(pa) * 64'(pb);
    pp_sh = 128'(pp) << (32 * (int'(step_q[1]) + int'(step_q[0])));
  end

  always_comb begin
    biased = acc_q;
    if (neg_q) biased = acc_q + (f24_q ? 128'hFF_FFFF : 128'hFFFF);
    shifted = f24_q ? (biased >> CovFrac) : (biased >> SigFrac);
    clip_o = 1'b0;
    if (shifted[127:64] != 64'd0) clip_o = 1'b1;
    else if (!neg_q && shifted[63]) clip_o = 1'b1;
    else if (neg_q && shifted[63] && shifted[62:0] != 63'd0) clip_o = 1'b1;
    if (clip_o) res_o = neg_q ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else res_o = neg_q ? 64'(-shifted[63:0]) : shifted[63:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        ma_q   <= a_i[63] ? 64'(-a_i) : a_i;
        mb_q   <= b_i[63] ? 64'(-b_i) : b_i;
        neg_q  <= a_i[63] ^ b_i[63];
        f24_q  <= frac24_i;
        acc_q  <= '0;
        step_q <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        acc_q  <= acc_q + pp_sh;
        step_q <= step_q + 3'd1;
        if (step_q == 3'd3) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_q)
    else $error("multiplier done while busy");
endmodule

FILE: rtl/rls_div.sv
// Radix-2 restoring divider: trunc(num * 2^sh / den), saturated to 64 bits.
// One quotient bit per cycle over 128 bits; a zero divisor ends the division early. Depends on rls_pkg.
`timescale 1ns / 1ps
module rls_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  input  logic        frac24_i,
  output logic        done_o,
  output logic [63:0] res_o,
  output logic        clip_o
);
  import rls_pkg::*;

  logic [127:0] n_q, q_q;
  logic [63:0]  d_q;
  logic [64:0]  rem_q, rem_sh;
  logic [6:0]   cnt_q;
  logic         busy_q, neg_q, zero_q, znum_q, nsign_q;
  logic [63:0]  mn;

  assign mn = num_i[63] ? 64'(-num_i) : num_i;
  assign rem_sh = {rem_q[63:0], n_q[127]};

  always_comb begin
    clip_o = 1'b0;
    res_o = '0;
    if (zero_q) begin
      clip_o = !znum_q;
      if (!znum_q) res_o = nsign_q ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      if (q_q[127:64] != 64'd0) clip_o = 1'b1;
      else if (!neg_q && q_q[63]) clip_o = 1'b1;
      else if (neg_q && q_q[63] && q_q[62:0] != 63'd0) clip_o = 1'b1;
      if (clip_o) res_o = neg_q ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      else res_o = neg_q ? 64'(-q_q[63:0]) : q_q[63:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        n_q     <= frac24_i ? (128'(mn) << CovFrac) : (128'(mn) << SigFrac);
        d_q     <= den_i[63] ? 64'(-den_i) : den_i;
        neg_q   <= num_i[63] ^ den_i[63];
        nsign_q <= num_i[63];
        zero_q  <= den_i == 64'd0;
        znum_q  <= num_i == 64'd0;
        rem_q   <= '0;
        q_q     <= '0;
        cnt_q   <= '0;
        busy_q  <= 1'b1;
      end else if (busy_q) begin
        n_q <= n_q << 1;
        if (rem_sh >= {1'b0, d_q}) begin
          rem_q <= rem_sh - {1'b0, d_q};
          q_q   <= {q_q[126:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          q_q   <= {q_q[126:0], 1'b0};
        end
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd127 || zero_q) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |=> busy_q)
    else $error("divider did not start");
endmodule

FILE: rtl/rls_datapath.sv
// Datapath of the RLS estimator: state, config, intermediates, shared multiplier and divider.
// Depends on rls_pkg, rls_mul and rls_div.
`timescale 1ns / 1ps
module rls_datapath #(
  parameter int SIGNAL_WIDTH = 32,
  parameter int COV_WIDTH    = 48
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rls_pkg::rls_cmd_t           cmd_i,
  output rls_pkg::rls_stat_t          stat_o,
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_idx_i,
  input  logic [30:0]                 cfg_data_i,
  input  logic signed [SIGNAL_WIDTH-1:0] voltage_i,
  input  logic signed [SIGNAL_WIDTH-1:0] current_i,
  input  logic signed [SIGNAL_WIDTH-1:0] angular_rate_i,
  output logic signed [SIGNAL_WIDTH-1:0] w0_o,
  output logic signed [SIGNAL_WIDTH-1:0] w1_o,
  output logic signed [COV_WIDTH-1:0]    p00_o,
  output logic signed [COV_WIDTH-1:0]    p01_o,
  output logic signed [COV_WIDTH-1:0]    p11_o,
  output logic                           clip_o
);
  import rls_pkg::*;

  logic [16:0] lam_q;
  logic [30:0] thr_q;
  logic [63:0] v_q, e0_q, e1_q;
  logic [63:0] w0_q, w1_q, p00_q, p01_q, p11_q;
  logic [63:0] pe0_q, pe1_q, den_q, g0_q, g1_q, err_q, t_q;
  logic [63:0] nw0_q, nw1_q, c0_q, c1_q, c2_q;
  logic        clip_q, excited_q;
  logic [63:0] mul_a, mul_b, mul_res, div_num, div_den, div_res;
  logic        mul_f24, div_f24, mul_done, mul_clip, div_done, div_clip;
  logic [63:0] mag0, mag1, onecov;
  logic        oc;
  mul_op_e     op_q;
  div_op_e     dop_q;

  assign onecov = clamp64(64'd1 << CovFrac, COV_WIDTH, oc);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_f24 = 1'b0;
    case (cmd_i.mul_op)
      OpPe0a: begin mul_a = p00_q; mul_b = e0_q; end
      OpPe0b: begin mul_a = p01_q; mul_b = e1_q; end
      OpPe1a: begin mul_a = p01_q; mul_b = e0_q; end
      OpPe1b: begin mul_a = p11_q; mul_b = e1_q; end
      OpDen0: begin mul_a = e0_q; mul_b = pe0_q; end
      OpDen1: begin mul_a = e1_q; mul_b = pe1_q; end
      OpErr0: begin mul_a = e0_q; mul_b = w0_q; end
      OpErr1: begin mul_a = e1_q; mul_b = w1_q; end
      OpW0:   begin mul_a = g0_q; mul_b = err_q; mul_f24 = 1'b1; end
      OpW1:   begin mul_a = g1_q; mul_b = err_q; mul_f24 = 1'b1; end
      OpC0:   begin mul_a = pe0_q; mul_b = g0_q; mul_f24 = 1'b1; end
      OpC1:   begin mul_a = pe1_q; mul_b = g0_q; mul_f24 = 1'b1; end
      OpC2:   begin mul_a = pe1_q; mul_b = g1_q; mul_f24 = 1'b1; end
      default: ;
    endcase
  end

  always_comb begin
    div_num = c0_q;
    div_den = 64'(lam_q);
    div_f24 = 1'b0;
    case (cmd_i.div_op)
      DivG0: begin div_num = pe0_q; div_den = den_q; div_f24 = 1'b1; end
      DivG1: begin div_num = pe1_q; div_den = den_q; div_f24 = 1'b1; end
      DivP0: div_num = c0_q;
      DivP1: div_num = c1_q;
      DivP2: div_num = c2_q;
      default: ;
    endcase
  end

  rls_mul u_mul (
    .clk_i, .rst_ni, .start_i(cmd_i.mul_go), .a_i(mul_a), .b_i(mul_b), .frac24_i(mul_f24),
    .done_o(mul_done), .res_o(mul_res), .clip_o(mul_clip)
  );

  rls_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_go), .num_i(div_num), .den_i(div_den),
    .frac24_i(div_f24), .done_o(div_done), .res_o(div_res), .clip_o(div_clip)
  );

  assign mag0 = e0_q[63] ? 64'(-e0_q) : e0_q;
  assign mag1 = e1_q[63] ? 64'(-e1_q) : e1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lam_q <= LambdaReset;
      thr_q <= ThresholdReset;
      w0_q <= '0;
      w1_q <= '0;
      p00_q <= onecov;
      p01_q <= '0;
      p11_q <= onecov;
      clip_q <= 1'b0;
      excited_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegLambda) lam_q <= cfg_data_i[16:0];
        else thr_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        v_q  <= 64'(voltage_i);
        e0_q <= 64'(current_i);
        e1_q <= 64'(angular_rate_i);
        clip_q <= 1'b0;
      end
      excited_q <= (mag0 > 64'(thr_q)) && (mag1 > 64'(thr_q));
      if (cmd_i.mul_go) op_q <= cmd_i.mul_op;
      if (cmd_i.div_go) dop_q <= cmd_i.div_op;
      if (mul_done) begin : mul_wb
        logic c, c2;
        logic [63:0] s;
        c = 1'b0;
        c2 = 1'b0;
        s = '0;
        case (op_q)
          OpPe0a, OpPe1a, OpDen0, OpErr0: t_q <= mul_res;
          OpPe0b: pe0_q <= sat_add64(t_q, mul_res, c);
          OpPe1b: pe1_q <= sat_add64(t_q, mul_res, c);
          OpDen1: begin
            s = sat_add64(t_q, mul_res, c);
            den_q <= sat_add64(s, 64'(lam_q) << (CovFrac - 16), c2);
          end
          OpErr1: begin
            s = sat_add64(t_q, mul_res, c);
            err_q <= sat_sub64(v_q, s, c2);
          end
          OpW0: begin
            s = sat_add64(w0_q, mul_res, c);
            nw0_q <= clamp64(s, SIGNAL_WIDTH, c2);
          end
          OpW1: begin
            s = sat_add64(w1_q, mul_res, c);
            nw1_q <= clamp64(s, SIGNAL_WIDTH, c2);
          end
          OpC0: c0_q <= sat_sub64(p00_q, mul_res, c);
          OpC1: c1_q <= sat_sub64(p01_q, mul_res, c);
          OpC2: c2_q <= sat_sub64(p11_q, mul_res, c);
          default: ;
        endcase
        if (mul_clip || c || c2) clip_q <= 1'b1;
      end
      if (div_done) begin : div_wb
        logic c;
        c = 1'b0;
        case (dop_q)
          DivG0: g0_q <= div_res;
          DivG1: g1_q <= div_res;
          DivP0: p00_q <= clamp64(div_res, COV_WIDTH, c);
          DivP1: p01_q <= clamp64(div_res, COV_WIDTH, c);
          DivP2: p11_q <= clamp64(div_res, COV_WIDTH, c);
          default: ;
        endcase
        if (div_clip || c) clip_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        w0_q <= nw0_q;
        w1_q <= nw1_q;
      end
    end
  end

  assign stat_o.excited  = excited_q;
  assign stat_o.mul_done = mul_done;
  assign stat_o.div_done = div_done;
  assign w0_o  = w0_q[SIGNAL_WIDTH-1:0];
  assign w1_o  = w1_q[SIGNAL_WIDTH-1:0];
  assign p00_o = p00_q[COV_WIDTH-1:0];
  assign p01_o = p01_q[COV_WIDTH-1:0];
  assign p11_o = p11_q[COV_WIDTH-1:0];
  assign clip_o = clip_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(mul_done && cmd_i.mul_go))
    else $error("multiplier restarted on completion cycle");
endmodule

FILE: rtl/rls_ctrl.sv
// Controller of the RLS estimator: sequences the multiply and divide operations.
// Depends on rls_pkg.
`timescale 1ns / 1ps
module rls_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               updated_o,
  output rls_pkg::rls_cmd_t  cmd_o,
  input  rls_pkg::rls_stat_t stat_i
);
  import rls_pkg::*;

  typedef enum logic [2:0] {SIdle, SCheck, SMul, SDiv, SOut} state_e;

  state_e   state_q;
  mul_op_e  mop_q;
  div_op_e  dop_q;
  logic     wait_q;
  rls_cmd_t cmd_q;

  assign in_ready_o = (state_q == SIdle) || (state_q == SOut && out_ready_i);

  // The sample is captured at the accepting edge, while its payload is still on the ports.
  always_comb begin
    cmd_o = cmd_q;
    cmd_o.load = in_valid_i && in_ready_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      out_valid_o <= 1'b0;
      updated_o <= 1'b0;
      mop_q <= OpPe0a;
      dop_q <= DivG0;
      wait_q <= 1'b0;
      cmd_q <= '0;
    end else begin
      cmd_q.mul_go <= 1'b0;
      cmd_q.div_go <= 1'b0;
      cmd_q.commit <= 1'b0;
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      case (state_q)
        SIdle, SOut: begin
          if (state_q == SIdle || out_ready_i) state_q <= SIdle;
          if (in_valid_i && in_ready_o) begin
            state_q <= SCheck;
            wait_q <= 1'b1;
          end
        end
        SCheck: begin
          // wait_q holds off the decision until the registered threshold compare has seen the new sample.
          if (wait_q) wait_q <= 1'b0;
          else if (stat_i.excited) begin
            mop_q <= OpPe0a;
            cmd_q.mul_go <= 1'b1;
            cmd_q.mul_op <= OpPe0a;
            state_q <= SMul;
          end else begin
            updated_o <= 1'b0;
            out_valid_o <= 1'b1;
            state_q <= SOut;
          end
        end
        SMul: begin
          if (stat_i.mul_done) begin
            if (mop_q == OpDen1) begin
              dop_q <= DivG0;
              cmd_q.div_go <= 1'b1;
              cmd_q.div_op <= DivG0;
              state_q <= SDiv;
            end else if (mop_q == OpC2) begin
              dop_q <= DivP0;
              cmd_q.div_go <= 1'b1;
              cmd_q.div_op <= DivP0;
              state_q <= SDiv;
            end else begin
              mop_q <= mul_op_e'(mop_q + 4'd1);
              cmd_q.mul_go <= 1'b1;
              cmd_q.mul_op <= mul_op_e'(mop_q + 4'd1);
            end
          end
        end
        SDiv: begin
          if (stat_i.div_done) begin
            if (dop_q == DivG1) begin
              mop_q <= OpErr0;
              cmd_q.mul_go <= 1'b1;
              cmd_q.mul_op <= OpErr0;
              state_q <= SMul;
            end else if (dop_q == DivP2) begin
              updated_o <= 1'b1;
              out_valid_o <= 1'b1;
              state_q <= SOut;
            end else begin
              // New weights land during the last division, before the result is shown.
              if (dop_q == DivP1) cmd_q.commit <= 1'b1;
              dop_q <= div_op_e'(dop_q + 3'd1);
              cmd_q.div_go <= 1'b1;
              cmd_q.div_op <= div_op_e'(dop_q + 3'd1);
            end
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_o.load |-> !out_valid_o ||
    out_ready_i)
    else $error("load with pending result");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(cmd_o.mul_go && cmd_o.div_go))
    else $error("both units started together");
endmodule

FILE: rtl/rls_two_parameter_estimator_unit.sv
// Two-parameter recursive least-squares estimator of motor resistance and motor constant.
// Input channel: voltage, current and angular rate under valid/ready.
// Output channel: weights, covariance, updated and saturated flags under valid/ready.
// Configuration: write enable, index (0 lambda, 1 threshold) and data, only while idle.
// A sample that fails the threshold test presents its result right after the threshold check,
// with no arithmetic. An updating sample runs 13 multiplies on one shared
// 32x32 partial-product multiplier and 5 divisions on one radix-2 divider.
// One sample is processed at a time; the next is accepted in the cycle its result is taken.
// Reset clears weights to zero and covariance to identity and sets the default registers.
// A stalled receiver holds the result stable and blocks new samples.
`timescale 1ns / 1ps
module rls_two_parameter_estimator_unit #(
  parameter int SIGNAL_WIDTH = 32,
  parameter int COV_WIDTH    = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [0:0]                     cfg_idx_i,
  input  logic [30:0]                    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SIGNAL_WIDTH-1:0] voltage_i,
  input  logic signed [SIGNAL_WIDTH-1:0] current_i,
  input  logic signed [SIGNAL_WIDTH-1:0] angular_rate_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SIGNAL_WIDTH-1:0] resistance_estimate_o,
  output logic signed [SIGNAL_WIDTH-1:0] motor_constant_estimate_o,
  output logic signed [COV_WIDTH-1:0]    cov_00_o,
  output logic signed [COV_WIDTH-1:0]    cov_01_o,
  output logic signed [COV_WIDTH-1:0]    cov_11_o,
  output logic                           updated_o,
  output logic                           saturated_o
);
  import rls_pkg::*;

  rls_cmd_t  cmd;
  rls_stat_t stat;
  logic      clip;

  rls_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .updated_o, .cmd_o(cmd), .stat_i(stat)
  );

  rls_datapath #(.SIGNAL_WIDTH(SIGNAL_WIDTH), .COV_WIDTH(COV_WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .voltage_i, .current_i, .angular_rate_i,
    .w0_o(resistance_estimate_o), .w1_o(motor_constant_estimate_o),
    .p00_o(cov_00_o), .p01_o(cov_01_o), .p11_o(cov_11_o), .clip_o(clip)
  );

  assign saturated_o = updated_o && clip;
endmodule
